// ===== hw/rtl/frsl_pkg.sv =====
// Package for the flash record slot log.
// Holds function and status codes, the controller state type and the command struct.
// No dependencies.
`default_nettype none
package frsl_pkg;

   localparam logic [1:0] FUNC_WRITE       = 2'd0;
   localparam logic [1:0] FUNC_READ_NEWEST = 2'd1;
   localparam logic [1:0] FUNC_READ_INDEX  = 2'd2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_INVAL  = 2'd1;
   localparam logic [1:0] STATUS_NODATA = 2'd2;

   localparam logic [31:0] EMPTY_STAMP = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hw/rtl/frsl_ctrl.sv =====
// Controller for the flash record slot log.
// Sequences capture, execute, memory load and response hold; uses frsl_pkg.
`default_nettype none
module frsl_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      frsl_pkg::cmd_type cmd
);
   import frsl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.exec    = 1'b0;
      cmd.load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_HOLD: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/frsl_dp.sv =====
// Datapath for the flash record slot log.
// Holds the stamp and payload memories, the fill count and the response registers;
// uses frsl_pkg.
`default_nettype none
module frsl_dp #(
   parameter int SLOT_COUNT   = 64,
   parameter int PAYLOAD_BITS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire frsl_pkg::cmd_type  cmd,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_record_stamp,
   input  wire logic [63:0]        req_record_data,
   input  wire logic               req_data_present,
   input  wire logic [6:0]         req_slot_index,
   output      logic [1:0]         rsp_status,
   output      logic [5:0]         rsp_slot_used,
   output      logic               rsp_page_erased,
   output      logic signed [31:0] rsp_stamp_out,
   output      logic [63:0]        rsp_data_out,
   output      logic               rsp_any_record
);
   import frsl_pkg::*;

   localparam int ADDR_W   = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
   localparam int IDX_W    = (CNT_W > 7) ? CNT_W : 7;
   localparam int IDXA_W   = (ADDR_W > 7) ? ADDR_W : 7;
   localparam int SLOTX_W  = (ADDR_W > 6) ? ADDR_W : 6;

   logic [31:0]             stamp_mem [SLOT_COUNT];
   logic [PAYLOAD_BITS-1:0] payload_mem [SLOT_COUNT];

   logic [1:0]              func_ff;
   logic [31:0]             stamp_ff;
   logic [PAYLOAD_BITS-1:0] data_ff;
   logic                    present_ff;
   logic [6:0]              index_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [31:0]             rd_stamp_ff;
   logic [PAYLOAD_BITS-1:0] rd_payload_ff;
   logic                    rd_ok_ff;

   logic [1:0]              status_ff;
   logic [5:0]              slot_ff;
   logic                    erased_ff;
   logic [31:0]             stamp_out_ff;
   logic [63:0]             data_out_ff;
   logic                    any_ff;

   logic [1:0]              status_in;
   logic [ADDR_W-1:0]       slot_in;
   logic                    erased_in;
   logic [CNT_W-1:0]        count_in;
   logic                    wr_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    rd_ok_in;
   logic                    full;
   logic [CNT_W-1:0]        count_m1;
   logic [IDX_W-1:0]        index_ext;
   logic [IDX_W-1:0]        count_ext;
   logic [IDXA_W-1:0]       index_adr;
   logic [SLOTX_W-1:0]      slot_ext;

   assign full      = (count_ff == CNT_W'(SLOT_COUNT));
   assign count_m1  = count_ff - CNT_W'(1);
   assign index_ext = IDX_W'(index_ff);
   assign count_ext = IDX_W'(count_ff);
   assign index_adr = IDXA_W'(index_ff);
   assign slot_ext  = SLOTX_W'(slot_in);

   always_comb begin
      status_in = STATUS_OK;
      slot_in   = '0;
      erased_in = 1'b0;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rd_addr   = index_adr[ADDR_W-1:0];
      rd_ok_in  = 1'b0;
      case (func_ff)
         FUNC_WRITE: begin
            if (!present_ff) begin
               status_in = STATUS_INVAL;
            end else begin
               wr_en = 1'b1;
               if (full) begin
                  erased_in = 1'b1;
                  slot_in   = '0;
                  count_in  = (stamp_ff != EMPTY_STAMP) ? CNT_W'(1) : '0;
               end else begin
                  slot_in  = count_ff[ADDR_W-1:0];
                  count_in = (stamp_ff != EMPTY_STAMP) ? count_ff + CNT_W'(1) : count_ff;
               end
            end
         end
         FUNC_READ_NEWEST: begin
            rd_addr = count_m1[ADDR_W-1:0];
            if (count_ff == '0) begin
               status_in = STATUS_NODATA;
            end else begin
               slot_in  = count_m1[ADDR_W-1:0];
               rd_ok_in = 1'b1;
            end
         end
         FUNC_READ_INDEX: begin
            if (index_ext < count_ext) begin
               slot_in  = index_adr[ADDR_W-1:0];
               rd_ok_in = 1'b1;
            end else begin
               status_in = STATUS_NODATA;
            end
         end
         default: begin
            status_in = STATUS_INVAL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req_func;
         stamp_ff   <= req_record_stamp;
         data_ff    <= req_record_data[PAYLOAD_BITS-1:0];
         present_ff <= req_data_present;
         index_ff   <= req_slot_index;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         stamp_mem[slot_in]   <= stamp_ff;
         payload_mem[slot_in] <= data_ff;
      end
      rd_stamp_ff   <= stamp_mem[rd_addr];
      rd_payload_ff <= payload_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         slot_ff   <= slot_ext[5:0];
         erased_ff <= erased_in;
         any_ff    <= (count_in != '0);
         rd_ok_ff  <= rd_ok_in;
      end
      if (cmd.load) begin
         stamp_out_ff <= rd_ok_ff ? rd_stamp_ff : '0;
         data_out_ff  <= rd_ok_ff ? 64'(rd_payload_ff) : '0;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_slot_used   = slot_ff;
   assign rsp_page_erased = erased_ff;
   assign rsp_stamp_out   = stamp_out_ff;
   assign rsp_data_out    = data_out_ff;
   assign rsp_any_record  = any_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/flash_record_slot_log.sv =====
// Top level of the flash record slot log.
// Joins frsl_ctrl and frsl_dp; uses frsl_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  func, record_stamp, record_data,
//                                              data_present, slot_index
//   rsp      out        rsp_valid / rsp_stall  status, slot_used, page_erased,
//                                              stamp_out, data_out, any_record
//
// One transaction at a time: accept, execute, registered memory read, present; req
// stays stalled after accept until the result is taken. Filled slots always form a
// prefix, so a fill count replaces any slot scan and a full-page erase resets the
// count and writes the new record to slot 0. Reset clears the count and the
// controller only; no clearing pass. While rsp is stalled the result holds and req
// stays stalled.
`default_nettype none
module flash_record_slot_log #(
   parameter int SLOT_COUNT   = 64,
   parameter int PAYLOAD_BITS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_record_stamp,
   input  wire logic [63:0]        req_record_data,
   input  wire logic               req_data_present,
   input  wire logic [6:0]         req_slot_index,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [1:0]         rsp_status,
   output      logic [5:0]         rsp_slot_used,
   output      logic               rsp_page_erased,
   output      logic signed [31:0] rsp_stamp_out,
   output      logic [63:0]        rsp_data_out,
   output      logic               rsp_any_record
);
   import frsl_pkg::*;

   cmd_type cmd;

   frsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   frsl_dp #(
      .SLOT_COUNT   (SLOT_COUNT),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_func         (req_func),
      .req_record_stamp (req_record_stamp),
      .req_record_data  (req_record_data),
      .req_data_present (req_data_present),
      .req_slot_index   (req_slot_index),
      .rsp_status       (rsp_status),
      .rsp_slot_used    (rsp_slot_used),
      .rsp_page_erased  (rsp_page_erased),
      .rsp_stamp_out    (rsp_stamp_out),
      .rsp_data_out     (rsp_data_out),
      .rsp_any_record   (rsp_any_record)
   );

endmodule
`default_nettype wire
